### src/lmac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmac_pkg;

	localparam int WINDOW_LENGTH_DEF = 50;

	localparam logic [63:0] START_RESET  = 64'h3FDF5C28F5C28F5C;
	localparam logic [31:0] WARMUP_RESET = 32'd1000000;
	localparam logic [63:0] TOL_RESET    = 64'h3D719799812DEA11;
	localparam logic [63:0] F64_ONE      = 64'h3FF0000000000000;
	localparam logic [63:0] F64_QNAN     = 64'h7FF8000000000000;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START  = 2'd0,
		CFG_WARMUP = 2'd1,
		CFG_TOL    = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		FOP_MUL = 1'b0,
		FOP_SUB = 1'b1
	} fpu_op_t;

	typedef struct packed {
		logic    start;
		fpu_op_t op;
	} fpu_req_t;

	function automatic logic f64_is_nan(input logic [63:0] v);
		return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
	endfunction

	// Ordered less-than; any NaN operand gives false
	function automatic logic f64_lt(input logic [63:0] a, input logic [63:0] b);
		logic res;
		res = 1'b0;
		if (f64_is_nan(a) || f64_is_nan(b)) begin
			res = 1'b0;
		end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
			res = 1'b0;
		end else if (a[63] != b[63]) begin
			res = a[63];
		end else if (!a[63]) begin
			res = a[62:0] < b[62:0];
		end else begin
			res = a[62:0] > b[62:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### src/lmac_fpu.sv
`timescale 1ns / 1ps
`default_nettype none

module lmac_fpu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lmac_pkg::fpu_req_t req,
	input  wire logic [63:0]       op_a,
	input  wire logic [63:0]       op_b,
	output logic                   done,
	output logic [63:0]            result
);
	import lmac_pkg::*;

	typedef enum logic [6:0] {
		F_IDLE  = 7'b0000001,
		F_MUL   = 7'b0000010,
		F_ALIGN = 7'b0000100,
		F_ADD   = 7'b0001000,
		F_NORM  = 7'b0010000,
		F_FIX   = 7'b0100000,
		F_RND   = 7'b1000000
	} fstate_t;

	fstate_t state_q;

	logic               sa_q, sb_q, sign_q, zs_q, sub_q;
	logic [10:0]        ea_q, eb_q;
	logic [52:0]        ma_q, mb_q;
	logic signed [13:0] e_q;
	logic [127:0]       m_q, mbig_q, msm_q;
	logic [105:0]       acc_q;
	logic [53:0]        pp_q;
	logic [2:0]         mcnt_q;
	logic [2:0]         nstep_q;
	logic               done_q;
	logic [63:0]        res_q;

	// Shift right, folding lost bits into the lowest bit
	function automatic logic [127:0] shr_sticky(input logic [127:0] v,
			input logic [13:0] amt);
		logic [127:0] sh;
		logic [127:0] lost;
		if (amt >= 14'd128) begin
			shr_sticky = {127'd0, |v};
		end else begin
			sh   = v >> amt[6:0];
			lost = v & ~({128{1'b1}} << amt[6:0]);
			shr_sticky = {sh[127:1], sh[0] | (|lost)};
		end
	endfunction

	// Operand unpack
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sbe;
	logic [10:0] ea_n, eb_n;
	logic [52:0] ma_n, mb_n;

	always_comb begin
		sbe    = op_b[63] ^ (req.op == FOP_SUB);
		a_nan  = f64_is_nan(op_a);
		b_nan  = f64_is_nan(op_b);
		a_inf  = (op_a[62:52] == 11'h7FF) && (op_a[51:0] == 52'd0);
		b_inf  = (op_b[62:52] == 11'h7FF) && (op_b[51:0] == 52'd0);
		a_zero = op_a[62:0] == 63'd0;
		b_zero = op_b[62:0] == 63'd0;
		ea_n   = (op_a[62:52] == 11'd0) ? 11'd1 : op_a[62:52];
		eb_n   = (op_b[62:52] == 11'd0) ? 11'd1 : op_b[62:52];
		ma_n   = {op_a[62:52] != 11'd0, op_a[51:0]};
		mb_n   = {op_b[62:52] != 11'd0, op_b[51:0]};
	end

	// Partial product select for the split 53x53 multiply
	logic [26:0] pa, pb;
	always_comb begin
		case (mcnt_q[1:0])
			2'd0: begin pa = ma_q[26:0];          pb = mb_q[26:0];          end
			2'd1: begin pa = {1'b0, ma_q[52:27]}; pb = mb_q[26:0];          end
			2'd2: begin pa = ma_q[26:0];          pb = {1'b0, mb_q[52:27]}; end
			default: begin pa = {1'b0, ma_q[52:27]}; pb = {1'b0, mb_q[52:27]}; end
		endcase
	end

	logic [105:0] acc_next;
	always_comb begin
		case (mcnt_q)
			3'd1:    acc_next = acc_q + 106'(pp_q);
			3'd2,
			3'd3:    acc_next = acc_q + (106'(pp_q) << 27);
			3'd4:    acc_next = acc_q + (106'(pp_q) << 54);
			default: acc_next = acc_q;
		endcase
	end

	// Alignment of the addend pair
	logic        a_big;
	logic [10:0] ediff;
	always_comb begin
		a_big = {ea_q, ma_q} >= {eb_q, mb_q};
		ediff = a_big ? (ea_q - eb_q) : (eb_q - ea_q);
	end

	// Normalize step size
	logic [7:0]         nk;
	logic signed [13:0] nk_s;
	logic               ntop_zero;
	always_comb begin
		nk        = 8'd64 >> nstep_q;
		nk_s      = $signed(14'(nk));
		ntop_zero = (m_q & ~({128{1'b1}} >> nk)) == 128'd0;
	end

	// Rounding to nearest even
	logic [52:0] rmant;
	logic        rup;
	logic [63:0] rsum;
	logic [10:0] rexp;
	always_comb begin
		rmant = m_q[127:75];
		rup   = m_q[74] & ((|m_q[73:0]) | rmant[0]);
		rexp  = 11'(e_q - 14'sd1);
		rsum  = {1'b0, rexp, 52'd0} + {11'd0, rmant} + {63'd0, rup};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
			mcnt_q  <= 3'd0;
			nstep_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (req.start) begin
						sa_q   <= op_a[63];
						sb_q   <= sbe;
						ea_q   <= ea_n;
						eb_q   <= eb_n;
						ma_q   <= ma_n;
						mb_q   <= mb_n;
						mcnt_q <= 3'd0;
						acc_q  <= '0;
						if (req.op == FOP_MUL) begin
							sign_q <= op_a[63] ^ op_b[63];
							e_q    <= $signed(14'(ea_n) + 14'(eb_n) - 14'd1022);
							if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
								res_q  <= F64_QNAN;
								done_q <= 1'b1;
							end else if (a_inf || b_inf) begin
								res_q  <= {op_a[63] ^ op_b[63], 11'h7FF, 52'd0};
								done_q <= 1'b1;
							end else begin
								state_q <= F_MUL;
							end
						end else begin
							if (a_nan || b_nan || (a_inf && b_inf && (op_a[63] != sbe))) begin
								res_q  <= F64_QNAN;
								done_q <= 1'b1;
							end else if (a_inf) begin
								res_q  <= op_a;
								done_q <= 1'b1;
							end else if (b_inf) begin
								res_q  <= {sbe, op_b[62:0]};
								done_q <= 1'b1;
							end else begin
								state_q <= F_ALIGN;
							end
						end
					end
				end
				F_MUL: begin
					// one partial product per cycle, accumulated in the following cycle from its register
					pp_q   <= pa * pb;
					acc_q  <= acc_next;
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd4) begin
						m_q     <= {acc_next, 22'd0};
						nstep_q <= 3'd0;
						state_q <= F_NORM;
					end
				end
				F_ALIGN: begin
					mbig_q  <= {1'b0, (a_big ? ma_q : mb_q), 74'd0};
					msm_q   <= shr_sticky({1'b0, (a_big ? mb_q : ma_q), 74'd0},
						14'(ediff));
					e_q     <= $signed(14'(a_big ? ea_q : eb_q) + 14'd1);
					sign_q  <= a_big ? sa_q : sb_q;
					sub_q   <= sa_q ^ sb_q;
					zs_q    <= sa_q & sb_q;
					state_q <= F_ADD;
				end
				F_ADD: begin
					m_q     <= sub_q ? (mbig_q - msm_q) : (mbig_q + msm_q);
					if (sub_q && (mbig_q == msm_q)) begin
						sign_q <= zs_q;
					end
					nstep_q <= 3'd0;
					state_q <= F_NORM;
				end
				F_NORM: begin
					// binary search of the leading one, bounded by the
					// smallest normal exponent
					if (ntop_zero && (e_q > nk_s)) begin
						m_q <= m_q << nk;
						e_q <= e_q - nk_s;
					end
					nstep_q <= nstep_q + 3'd1;
					if (nstep_q == 3'd6) begin
						state_q <= F_FIX;
					end
				end
				F_FIX: begin
					if (e_q < 14'sd1) begin
						m_q <= shr_sticky(m_q, 14'(14'sd1 - e_q));
						e_q <= 14'sd1;
					end
					state_q <= F_RND;
				end
				F_RND: begin
					if (m_q == 128'd0) begin
						res_q <= {sign_q, 63'd0};
					end else if ((e_q > 14'sd2047) || (rsum[63:52] >= 12'h7FF)) begin
						res_q <= {sign_q, 11'h7FF, 52'd0};
					end else begin
						res_q <= {sign_q, rsum[62:0]};
					end
					done_q  <= 1'b1;
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

### src/logistic_map_attractor_count_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Each iteration runs a multiply, a subtract and a multiply on the binary64 unit (an operation
//   ends early when an operand is NaN or infinite) for warmup_count + WINDOW_LENGTH iterations,
//   then each window entry is compared by subtraction with earlier entries until one is near.
// A new rate is taken only in idle, after the last result is loaded; one shared iterative
//   binary64 unit does every multiply and subtract. Reset: asynchronous, active low; registers
//   return to start 0.49, warm-up 1000000, tolerance 1e-12. Window memory content is undefined until written.
module logistic_map_attractor_count_unit #(
	parameter int WINDOW_LENGTH = lmac_pkg::WINDOW_LENGTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [63:0]                   s_axis_tdata,  // [63:0] rate_bits
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [7:0]                         m_axis_tdata,  // [6:0] distinct_count, [7] zero
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lmac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                   cfg_data
);
	import lmac_pkg::*;

	localparam int IW = $clog2(WINDOW_LENGTH);
	localparam int CW = $clog2(WINDOW_LENGTH + 1);
	localparam logic [CW-1:0] LAST_IDX = CW'(WINDOW_LENGTH - 1);
	localparam logic [CW-1:0] WIN_LEN  = CW'(WINDOW_LENGTH);

	typedef enum logic [8:0] {
		T_IDLE   = 9'b000000001,
		T_MUL_RX = 9'b000000010,
		T_SUB_X  = 9'b000000100,
		T_MUL_Y  = 9'b000001000,
		T_RD_I   = 9'b000010000,
		T_LD_I   = 9'b000100000,
		T_RD_J   = 9'b001000000,
		T_CMP    = 9'b010000000,
		T_OUT    = 9'b100000000
	} tstate_t;

	tstate_t state_q;

	logic [63:0]   start_q, tol_q;
	logic [31:0]   warm_q;
	logic [63:0]   rate_q, x_q, t1_q, t2_q, xi_q;
	logic [31:0]   cnt_q;
	logic          rec_q;
	logic          wait_q;
	logic [CW-1:0] widx_q, i_q, j_q;
	logic [6:0]    count_q;
	logic          out_valid_q;
	logic [6:0]    out_data_q;

	// Window memory, one write and one registered read port
	logic [63:0] mem [WINDOW_LENGTH];
	logic [63:0] rd_q;
	logic        mem_we, mem_re;
	logic [IW-1:0] mem_raddr;

	fpu_req_t    fpu_req;
	logic [63:0] fpu_a, fpu_b, fpu_res;
	logic        fpu_done;

	lmac_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.op_a   (fpu_a),
		.op_b   (fpu_b),
		.done   (fpu_done),
		.result (fpu_res)
	);

	// Operand routing per step
	always_comb begin
		fpu_req.start = 1'b0;
		fpu_req.op    = FOP_MUL;
		fpu_a         = rate_q;
		fpu_b         = x_q;
		unique case (state_q)
			T_MUL_RX: begin
				fpu_req.start = !wait_q;
			end
			T_SUB_X: begin
				fpu_req.start = !wait_q;
				fpu_req.op    = FOP_SUB;
				fpu_a         = F64_ONE;
			end
			T_MUL_Y: begin
				fpu_req.start = !wait_q;
				fpu_a         = t1_q;
				fpu_b         = t2_q;
			end
			T_CMP: begin
				fpu_req.start = !wait_q;
				fpu_req.op    = FOP_SUB;
				fpu_a         = xi_q;
				fpu_b         = rd_q;
			end
			default: ;
		endcase
	end

	logic near_hit;
	always_comb begin
		near_hit = f64_lt(fpu_res, tol_q) && f64_lt({~fpu_res[63], fpu_res[62:0]}, tol_q);
	end

	assign mem_we    = (state_q == T_MUL_Y) && fpu_done && rec_q;
	assign mem_re    = (state_q == T_RD_I) || (state_q == T_RD_J);
	assign mem_raddr = (state_q == T_RD_I) ? i_q[IW-1:0] : j_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[widx_q[IW-1:0]] <= fpu_res;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
			warm_q  <= WARMUP_RESET;
			tol_q   <= TOL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START:  start_q <= cfg_data;
				CFG_WARMUP: warm_q  <= cfg_data[31:0];
				CFG_TOL:    tol_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = (state_q == T_IDLE);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			wait_q      <= 1'b0;
			rec_q       <= 1'b0;
			cnt_q       <= '0;
			widx_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Hold the result until taken, load a new one when the slot frees
			if ((state_q == T_OUT) && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (fpu_req.start) begin
				wait_q <= 1'b1;
			end
			unique case (state_q)
				T_IDLE: begin
					if (s_axis_tvalid) begin
						rate_q  <= s_axis_tdata;
						x_q     <= start_q;
						cnt_q   <= '0;
						rec_q   <= (warm_q == 32'd0);
						widx_q  <= '0;
						state_q <= T_MUL_RX;
					end
				end
				T_MUL_RX: begin
					if (fpu_done) begin
						t1_q    <= fpu_res;
						wait_q  <= 1'b0;
						state_q <= T_SUB_X;
					end
				end
				T_SUB_X: begin
					if (fpu_done) begin
						t2_q    <= fpu_res;
						wait_q  <= 1'b0;
						state_q <= T_MUL_Y;
					end
				end
				T_MUL_Y: begin
					if (fpu_done) begin
						x_q    <= fpu_res;
						wait_q <= 1'b0;
						state_q <= T_MUL_RX;
						if (rec_q) begin
							widx_q <= widx_q + 1'b1;
							if (widx_q == LAST_IDX) begin
								i_q     <= CW'(1);
								j_q     <= '0;
								count_q <= 7'd1;
								state_q <= T_RD_I;
							end
						end else begin
							cnt_q <= cnt_q + 32'd1;
							if (cnt_q + 32'd1 == warm_q) begin
								rec_q <= 1'b1;
							end
						end
					end
				end
				T_RD_I: begin
					state_q <= T_LD_I;
				end
				T_LD_I: begin
					xi_q    <= rd_q;
					state_q <= T_RD_J;
				end
				T_RD_J: begin
					state_q <= T_CMP;
				end
				T_CMP: begin
					if (fpu_done) begin
						wait_q <= 1'b0;
						if (near_hit || (j_q + 1'b1 == i_q)) begin
							// entry settled: advance to next entry
							if (!near_hit) begin
								count_q <= count_q + 7'd1;
							end
							j_q <= '0;
							i_q <= i_q + 1'b1;
							state_q <= (i_q + 1'b1 == WIN_LEN) ? T_OUT : T_RD_I;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= T_RD_J;
						end
					end
				end
				T_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= count_q;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_data_q};

endmodule

`default_nettype wire

### src/lmac_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module lmac_chk #(
	parameter int WINDOW_LENGTH = lmac_pkg::WINDOW_LENGTH_DEF
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_axis_tvalid,
	input wire logic                           s_axis_tready,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	input wire logic [7:0]                     m_axis_tdata
);

	// Count stays within one and the window length
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[6:0] != 7'd0) &&
			(m_axis_tdata[6:0] <= 7'(WINDOW_LENGTH)) && !m_axis_tdata[7])
		else $error("distinct count out of range");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	// One request in work at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	// A result cannot appear right after a request that finds no result pending
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result without work");

endmodule

bind logistic_map_attractor_count_unit lmac_chk #(
	.WINDOW_LENGTH(WINDOW_LENGTH)
) u_lmac_chk (.*);

`default_nettype wire
